### design/timer_capture_and_overflow_extender_assert.svh
// ============================================================================
// Timer capture and overflow extender: assertion macros
// Shared concurrent assertion forms used by the checker.
// ============================================================================
`ifndef TIMER_CAPTURE_AND_OVERFLOW_EXTENDER_ASSERT_SVH
`define TIMER_CAPTURE_AND_OVERFLOW_EXTENDER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TCOE_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tcoe assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define TCOE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tcoe assertion failed");

`endif

### design/tcoe_pkg.sv
// ============================================================================
// Timer capture and overflow extender: package
// Payload types, register indexes and mode codes shared by the design.
// ============================================================================
`timescale 1ns / 1ps

package tcoe_pkg;

    localparam int CH_W     = 2;
    localparam int CNT_W    = 16;
    localparam int MEAS_W   = 17;
    localparam int EXT_W    = 48;
    localparam int MODE_W   = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // Mode codes; codes above MODE_PWM also mean no action.
    localparam logic [MODE_W-1:0] MODE_TIMER   = 3'd0;
    localparam logic [MODE_W-1:0] MODE_CAPTURE = 3'd1;
    localparam logic [MODE_W-1:0] MODE_COUNTER = 3'd2;
    localparam logic [MODE_W-1:0] MODE_ENCODER = 3'd3;
    localparam logic [MODE_W-1:0] MODE_PWM     = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WRAP = 2'd1;

    localparam logic [MODE_W-1:0] MODE_RESET = MODE_PWM;
    localparam logic [CNT_W-1:0]  WRAP_RESET = 16'hFFFF;

    // Overflow step and encoder direction split.
    localparam logic [CNT_W-1:0] OVF_STEP  = 16'd60000;
    localparam logic [CNT_W-1:0] DIR_SPLIT = 16'd30000;

    typedef struct packed {
        logic [CH_W-1:0]  channel;
        logic [CNT_W-1:0] capture_value;
        logic [CNT_W-1:0] counter_value;
    } t_event;

    typedef struct packed {
        logic                    tick_pulse;
        logic                    was_rising;
        logic [MEAS_W-1:0]       high_time;
        logic [MEAS_W-1:0]       low_time;
        logic [MEAS_W-1:0]       period_rise;
        logic [MEAS_W-1:0]       period_fall;
        logic signed [EXT_W-1:0] extended_count;
    } t_result;

    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_DAT_W-1:0] data;
    } t_cfg;

    // Request from the top level to the capture unit.
    typedef struct packed {
        logic             commit;
        logic             capture;
        logic [CH_W-1:0]  channel;
        logic [CNT_W-1:0] capture_value;
        logic [CNT_W-1:0] wrap_period;
    } t_cap_req;

    // Measurements of the addressed channel after this event.
    typedef struct packed {
        logic              was_rising;
        logic [MEAS_W-1:0] high_time;
        logic [MEAS_W-1:0] low_time;
        logic [MEAS_W-1:0] period_rise;
        logic [MEAS_W-1:0] period_fall;
    } t_meas;

    // Request from the top level to the accumulator.
    typedef struct packed {
        logic              commit;
        logic [MODE_W-1:0] mode;
        logic [CNT_W-1:0]  counter_value;
    } t_acc_req;

endpackage

### design/tcoe_stream_if.sv
// ============================================================================
// Timer capture and overflow extender: stream interface
// Valid/ready channel carrying one payload of a chosen type.
// ============================================================================
`timescale 1ns / 1ps

interface tcoe_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

### design/tcoe_capture.sv
// ============================================================================
// Timer capture and overflow extender: capture unit
// Per-channel edge state, time stamps and measured durations and periods.
// ============================================================================
`timescale 1ns / 1ps

module tcoe_capture
    import tcoe_pkg::*;
#(
    parameter int NUM_CHANNELS = 4
) (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_cap_req i_req,
    output t_meas    o_meas
);

    logic              r_next_rising [NUM_CHANNELS];
    logic [CNT_W-1:0]  r_rise_stamp  [NUM_CHANNELS];
    logic [CNT_W-1:0]  r_fall_stamp  [NUM_CHANNELS];
    logic [MEAS_W-1:0] r_high        [NUM_CHANNELS];
    logic [MEAS_W-1:0] r_low         [NUM_CHANNELS];
    logic [MEAS_W-1:0] r_prise       [NUM_CHANNELS];
    logic [MEAS_W-1:0] r_pfall       [NUM_CHANNELS];

    logic              ch_ok;
    logic              sel_next;
    logic [CNT_W-1:0]  sel_rise_stamp;
    logic [CNT_W-1:0]  sel_fall_stamp;
    logic [MEAS_W-1:0] sel_high;
    logic [MEAS_W-1:0] sel_low;
    logic [MEAS_W-1:0] sel_prise;
    logic [MEAS_W-1:0] sel_pfall;
    logic              rise_evt;
    logic              fall_evt;
    logic [MEAS_W-1:0] span_from_rise;
    logic [MEAS_W-1:0] span_from_fall;

    // Elapsed ticks since a stamp; a difference that is not positive wraps
    // by the configured period, all modulo 2^17.
    function automatic logic [MEAS_W-1:0] span(
        input logic [CNT_W-1:0] now,
        input logic [CNT_W-1:0] stamp,
        input logic [CNT_W-1:0] wrap
    );
        if (now > stamp) begin
            return MEAS_W'(now) - MEAS_W'(stamp);
        end
        return MEAS_W'(wrap) + MEAS_W'(now) - MEAS_W'(stamp);
    endfunction

    always_comb begin
        ch_ok          = 1'b0;
        sel_next       = 1'b0;
        sel_rise_stamp = '0;
        sel_fall_stamp = '0;
        sel_high       = '0;
        sel_low        = '0;
        sel_prise      = '0;
        sel_pfall      = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            if (i_req.channel == CH_W'(i)) begin
                ch_ok          = 1'b1;
                sel_next       = r_next_rising[i];
                sel_rise_stamp = r_rise_stamp[i];
                sel_fall_stamp = r_fall_stamp[i];
                sel_high       = r_high[i];
                sel_low        = r_low[i];
                sel_prise      = r_prise[i];
                sel_pfall      = r_pfall[i];
            end
        end
    end

    assign rise_evt       = i_req.capture && ch_ok && sel_next;
    assign fall_evt       = i_req.capture && ch_ok && !sel_next;
    assign span_from_rise = span(i_req.capture_value, sel_rise_stamp, i_req.wrap_period);
    assign span_from_fall = span(i_req.capture_value, sel_fall_stamp, i_req.wrap_period);

    // Report values as they stand after this event's update.
    always_comb begin
        o_meas.was_rising  = rise_evt;
        o_meas.low_time    = rise_evt ? span_from_fall : sel_low;
        o_meas.period_rise = rise_evt ? span_from_rise : sel_prise;
        o_meas.high_time   = fall_evt ? span_from_rise : sel_high;
        o_meas.period_fall = fall_evt ? span_from_fall : sel_pfall;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_next_rising[i] <= 1'b1;
                r_rise_stamp[i]  <= '0;
                r_fall_stamp[i]  <= '0;
                r_high[i]        <= '0;
                r_low[i]         <= '0;
                r_prise[i]       <= '0;
                r_pfall[i]       <= '0;
            end
        end else if (i_req.commit && i_req.capture) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                if (i_req.channel == CH_W'(i)) begin
                    r_next_rising[i] <= !r_next_rising[i];
                    if (r_next_rising[i]) begin
                        r_low[i]        <= span_from_fall;
                        r_prise[i]      <= span_from_rise;
                        r_rise_stamp[i] <= i_req.capture_value;
                    end else begin
                        r_high[i]       <= span_from_rise;
                        r_pfall[i]      <= span_from_fall;
                        r_fall_stamp[i] <= i_req.capture_value;
                    end
                end
            end
        end
    end

endmodule

### design/tcoe_accum.sv
// ============================================================================
// Timer capture and overflow extender: overflow accumulator
// 48-bit overflow count and the extended count it yields.
// ============================================================================
`timescale 1ns / 1ps

module tcoe_accum
    import tcoe_pkg::*;
(
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  t_acc_req                i_req,
    output logic signed [EXT_W-1:0] o_extended
);

    logic signed [EXT_W-1:0]  r_acc;
    logic signed [CNT_W:0]    delta;
    logic signed [CNT_W+1:0]  delta_cnt;

    always_comb begin
        delta = '0;
        case (i_req.mode)
            MODE_COUNTER: delta = signed'({1'b0, OVF_STEP});
            MODE_ENCODER: begin
                if (i_req.counter_value < DIR_SPLIT) begin
                    delta = signed'({1'b0, OVF_STEP});
                end else begin
                    delta = -signed'({1'b0, OVF_STEP});
                end
            end
            default: delta = '0;
        endcase
    end

    // The step and the live counter are folded first so that the extended
    // count needs a single wide add.
    assign delta_cnt  = (CNT_W+2)'(delta) + signed'({2'b00, i_req.counter_value});
    assign o_extended = r_acc + EXT_W'(delta_cnt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_req.commit) begin
            r_acc <= r_acc + EXT_W'(delta);
        end
    end

endmodule

### design/timer_capture_and_overflow_extender.sv
// ============================================================================
// Timer capture and overflow extender
// Mode-dependent handling of timer events with pulse measurement and a
// 48-bit extended counter.
// ============================================================================
// Every transfer on i_evt is one timer event and produces exactly one result
// transfer on o_res, in order. While o_res accepts results, the block takes
// one event per clock cycle: an event lands in an input register, and when
// it moves on, the capture unit and the overflow accumulator work in a
// single pass while the result register is loaded; the event reaches o_res
// via both registers. The input register and the result register
// decouple the two sides, so one more event is taken while a finished result
// waits for o_res.ready. Channel state and the accumulator are read and
// updated in the same stage, so consecutive events see each other's effects
// with no gap. Configuration writes on i_cfg are always taken and should be
// made while no event is in flight. A channel number at or beyond
// NUM_CHANNELS changes no channel state and reports zero measurements.
// ============================================================================
`timescale 1ns / 1ps

module timer_capture_and_overflow_extender
    import tcoe_pkg::*;
#(
    parameter int NUM_CHANNELS = 4
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    tcoe_stream_if.sink   i_evt,
    tcoe_stream_if.source o_res,
    tcoe_stream_if.sink   i_cfg
);

    // Configuration registers.
    logic [MODE_W-1:0] r_mode;
    logic [CNT_W-1:0]  r_wrap;

    // Input register stage.
    logic   r_in_valid;
    t_event r_in;

    // Result register stage.
    logic    r_out_valid;
    t_result r_out;
    t_result n_out;

    logic                    advance;
    t_cap_req                cap_req;
    t_meas                   meas;
    t_acc_req                acc_req;
    logic signed [EXT_W-1:0] extended;

    // The held event moves on whenever the result register is empty or is
    // being drained in this cycle.
    assign advance     = r_in_valid && (!r_out_valid || o_res.ready);
    assign i_evt.ready = !r_in_valid || advance;
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_RESET;
            r_wrap <= WRAP_RESET;
        end else if (i_cfg.valid) begin
            if (i_cfg.payload.index == CFG_MODE) begin
                r_mode <= i_cfg.payload.data[MODE_W-1:0];
            end else if (i_cfg.payload.index == CFG_WRAP) begin
                r_wrap <= i_cfg.payload.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_evt.ready) begin
            r_in_valid <= i_evt.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_evt.valid && i_evt.ready) begin
            r_in <= i_evt.payload;
        end
    end

    // State in both units commits only when the event moves into the
    // result register.
    always_comb begin
        cap_req.commit        = advance;
        cap_req.capture       = (r_mode == MODE_CAPTURE);
        cap_req.channel       = r_in.channel;
        cap_req.capture_value = r_in.capture_value;
        cap_req.wrap_period   = r_wrap;
        acc_req.commit        = advance;
        acc_req.mode          = r_mode;
        acc_req.counter_value = r_in.counter_value;
    end

    tcoe_capture #(
        .NUM_CHANNELS (NUM_CHANNELS)
    ) u_capture (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cap_req),
        .o_meas  (meas)
    );

    tcoe_accum u_accum (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (acc_req),
        .o_extended (extended)
    );

    always_comb begin
        n_out.tick_pulse     = (r_mode == MODE_TIMER);
        n_out.was_rising     = meas.was_rising;
        n_out.high_time      = meas.high_time;
        n_out.low_time       = meas.low_time;
        n_out.period_rise    = meas.period_rise;
        n_out.period_fall    = meas.period_fall;
        n_out.extended_count = extended;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_res.valid   = r_out_valid;
    assign o_res.payload = r_out;

endmodule

### design/tcoe_checker.sv
// ============================================================================
// Timer capture and overflow extender: port checker
// Assertions on the top level's ports, attached by a bind statement.
// ============================================================================
`timescale 1ns / 1ps
`include "timer_capture_and_overflow_extender_assert.svh"

module tcoe_checker
    import tcoe_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    i_in_ready,
    input logic    i_out_valid,
    input logic    i_out_ready,
    input t_result i_out_payload
);

    // A stalled result stays offered and unchanged.
    `TCOE_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_out_payload))

    // A result rising on an idle output is an event taken via input and result registers.
    `TCOE_ASSERT_SAME(a_out_latency, i_clk, i_rst_n, $rose(i_out_valid), $past(i_in_valid && i_in_ready, 2))

    // A timer tick and a rising capture never come from the same event.
    `TCOE_ASSERT_SAME(a_tick_vs_rise, i_clk, i_rst_n, i_out_valid, !(i_out_payload.tick_pulse && i_out_payload.was_rising))

endmodule

bind timer_capture_and_overflow_extender tcoe_checker u_tcoe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_evt.valid),
    .i_in_ready    (i_evt.ready),
    .i_out_valid   (o_res.valid),
    .i_out_ready   (o_res.ready),
    .i_out_payload (o_res.payload)
);
